// ----- rtl/vtst_pkg.sv -----
// vehicle theft state tracker: shared types, codes and fixed-point constants
// no dependencies; used by every module of the block
`default_nettype none

package vtst_pkg;

  // datapath word for sine, cosine and multiplier operands (q30 with headroom)
  typedef logic signed [33:0] word_t;

  // operation codes of an input word
  localparam logic [2:0] OP_UPDATE   = 3'd0;
  localparam logic [2:0] OP_LOCK_ON  = 3'd1;
  localparam logic [2:0] OP_LOCK_OFF = 3'd2;
  localparam logic [2:0] OP_THEFT    = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_GEOFENCE_ON  = 3'd0;
  localparam logic [2:0] REG_CENTER_LAT   = 3'd1;
  localparam logic [2:0] REG_CENTER_LNG   = 3'd2;
  localparam logic [2:0] REG_RADIUS       = 3'd3;
  localparam logic [2:0] REG_MOTION_THR   = 3'd4;
  localparam logic [2:0] REG_SUSP_TIMEOUT = 3'd5;

  // register reset values
  localparam logic [24:0] RADIUS_RST  = 25'd1000;
  localparam logic [15:0] THR_RST     = 16'd100;
  localparam logic [31:0] TIMEOUT_RST = 32'd60000;

  // fixed-point constants
  localparam word_t GAIN_Q30 = 34'sd652032874;
  localparam word_t FULL_K   = 34'sd5124095576;
  localparam word_t HALF_K   = 34'sd2562047788;
  localparam word_t RAD_K    = 34'sd3515785;
  localparam word_t QUARTER  = 34'sd1073741824;

  typedef enum logic [2:0] {
    MD_NORMAL, MD_SUSPICIOUS, MD_STOLEN, MD_LOCKDOWN, MD_RECOVERED
  } mode_t;

  // multiplier operand pairs
  typedef enum logic [3:0] {
    MS_NONE, MS_DLAT, MS_DLNG, MS_CLAT, MS_LAT, MS_RAD,
    MS_SDL2, MS_C1C2, MS_SDG2, MS_P2P3, MS_ST2
  } mul_sel_t;

  // captures of multiplier results
  typedef enum logic [2:0] {
    CP_NONE, CP_P1, CP_P2, CP_HAV, CP_CMP
  } cap_sel_t;

  // which angle the cordic is working on
  typedef enum logic [2:0] {
    CD_SDL, CD_SDG, CD_C1, CD_C2, CD_ST
  } crd_dst_t;

  typedef struct packed {
    logic     load;
    logic     clear_fence;
    mul_sel_t mul_sel;
    logic     crd_start;
    logic     crd_cap;
    crd_dst_t crd_dst;
    cap_sel_t cap_sel;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic need_fence;
    logic hr_big;
    logic crd_done;
  } sts_t;

  // cordic arctangent table, binary angles with 2^32 per turn
  function automatic word_t atan_q(input logic [4:0] i);
    word_t v;
    case (i)
      5'd0:  v = 34'sh020000000;
      5'd1:  v = 34'sh012E4051E;
      5'd2:  v = 34'sh009FB385B;
      5'd3:  v = 34'sh0051111D4;
      5'd4:  v = 34'sh0028B0D43;
      5'd5:  v = 34'sh00145D7E1;
      5'd6:  v = 34'sh000A2F61E;
      5'd7:  v = 34'sh000517C55;
      5'd8:  v = 34'sh00028BE53;
      5'd9:  v = 34'sh000145F2F;
      5'd10: v = 34'sh0000A2F98;
      5'd11: v = 34'sh0000517CC;
      5'd12: v = 34'sh000028BE6;
      5'd13: v = 34'sh0000145F3;
      5'd14: v = 34'sh00000A2FA;
      5'd15: v = 34'sh00000517D;
      5'd16: v = 34'sh0000028BE;
      5'd17: v = 34'sh00000145F;
      5'd18: v = 34'sh000000A30;
      5'd19: v = 34'sh000000518;
      5'd20: v = 34'sh00000028C;
      5'd21: v = 34'sh000000146;
      5'd22: v = 34'sh0000000A3;
      5'd23: v = 34'sh000000051;
      5'd24: v = 34'sh000000029;
      5'd25: v = 34'sh000000014;
      5'd26: v = 34'sh00000000A;
      5'd27: v = 34'sh000000005;
      5'd28: v = 34'sh000000003;
      5'd29: v = 34'sh000000001;
      5'd30: v = 34'sh000000001;
      default: v = 34'sh000000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/vtst_cordic.sv -----
// iterative rotation cordic: one micro-rotation per cycle, q30 sine and cosine
// depends on vtst_pkg
`default_nettype none

module vtst_cordic #(
  parameter int STEPS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [31:0]         angle,
  output logic                     done,
  output vtst_pkg::word_t          cos_o,
  output vtst_pkg::word_t          sin_o
);

  localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;

  vtst_pkg::word_t x_r, y_r, z_r, z0;
  logic            neg_r, busy_r, done_r, neg0;
  logic [CW-1:0]   i_r;
  vtst_pkg::word_t dx, dy, at;

  // fold the start angle into the right half plane
  always_comb begin
    z0   = vtst_pkg::word_t'($signed(angle));
    neg0 = 1'b0;
    if (z0 > vtst_pkg::QUARTER) begin
      z0   = z0 - (vtst_pkg::QUARTER <<< 1);
      neg0 = 1'b1;
    end else if (z0 < -vtst_pkg::QUARTER) begin
      z0   = z0 + (vtst_pkg::QUARTER <<< 1);
      neg0 = 1'b1;
    end
  end

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign at = vtst_pkg::atan_q(5'(i_r));

  // rotation loop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= vtst_pkg::GAIN_Q30;
        y_r    <= '0;
        z_r    <= z0;
        neg_r  <= neg0;
        i_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        if (i_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign cos_o = neg_r ? -x_r : x_r;
  assign sin_o = neg_r ? -y_r : y_r;

endmodule

`default_nettype wire

// ----- rtl/vtst_dp.sv -----
// datapath: input and config registers, guard state, shared multiplier, cordic
// depends on vtst_pkg and vtst_cordic
`default_nettype none

module vtst_dp #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vtst_pkg::cmd_t      cmd,
  output vtst_pkg::sts_t           sts,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_wdata,
  input  wire logic [2:0]          in_operation,
  input  wire logic signed [30:0]  in_latitude,
  input  wire logic signed [31:0]  in_longitude,
  input  wire logic [15:0]         in_speed,
  input  wire logic                in_ignition_on,
  input  wire logic [31:0]         in_now_ms,
  output logic [2:0]               out_guard_mode,
  output logic                     out_stolen_flag,
  output logic                     out_lockdown_flag,
  output logic                     out_block_otp,
  output logic                     out_outside_fence,
  output logic signed [30:0]       out_last_latitude,
  output logic signed [31:0]       out_last_longitude,
  output logic [15:0]              out_last_speed
);

  // input word
  logic [2:0]         op_r;
  logic signed [30:0] lat_r;
  logic signed [31:0] lng_r;
  logic [15:0]        spd_r;
  logic               ign_r;
  logic [31:0]        now_r;

  // configuration
  logic               geo_on_r;
  logic signed [30:0] clat_r;
  logic signed [31:0] clng_r;
  logic [24:0]        radius_r;
  logic [15:0]        thr_r;
  logic [31:0]        timeout_r;

  // guard state
  vtst_pkg::mode_t    mode_r, mode_nxt;
  logic               stolen_r, stolen_nxt, locked_r, locked_nxt;
  logic [31:0]        ss_r, ss_nxt;
  logic signed [30:0] slat_r, slat_nxt;
  logic signed [31:0] slng_r, slng_nxt;
  logic [15:0]        sspd_r, sspd_nxt;
  logic               ofence_nxt, clr_cfg;

  // geofence arithmetic
  vtst_pkg::word_t    mul_a, mul_b, sh30;
  logic signed [67:0] prod_r;
  vtst_pkg::word_t    sdl_r, sdg_r, c1_r, c2_r, st_r, p1_r, p2_r;
  logic signed [35:0] hav_r;
  logic               fence_r;
  logic [31:0]        crd_angle;
  logic               crd_done;
  vtst_pkg::word_t    crd_cos, crd_sin;

  assign sh30 = vtst_pkg::word_t'(prod_r >>> 30);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      vtst_pkg::MS_DLAT: begin
        mul_a = vtst_pkg::word_t'(lat_r) - vtst_pkg::word_t'(clat_r);
        mul_b = vtst_pkg::HALF_K;
      end
      vtst_pkg::MS_DLNG: begin
        mul_a = vtst_pkg::word_t'(lng_r) - vtst_pkg::word_t'(clng_r);
        mul_b = vtst_pkg::HALF_K;
      end
      vtst_pkg::MS_CLAT: begin
        mul_a = vtst_pkg::word_t'(clat_r);
        mul_b = vtst_pkg::FULL_K;
      end
      vtst_pkg::MS_LAT: begin
        mul_a = vtst_pkg::word_t'(lat_r);
        mul_b = vtst_pkg::FULL_K;
      end
      vtst_pkg::MS_RAD: begin
        mul_a = vtst_pkg::word_t'({1'b0, radius_r});
        mul_b = vtst_pkg::RAD_K;
      end
      vtst_pkg::MS_SDL2: begin mul_a = sdl_r; mul_b = sdl_r; end
      vtst_pkg::MS_C1C2: begin mul_a = c1_r;  mul_b = c2_r;  end
      vtst_pkg::MS_SDG2: begin mul_a = sdg_r; mul_b = sdg_r; end
      vtst_pkg::MS_P2P3: begin mul_a = p2_r;  mul_b = sh30;  end
      vtst_pkg::MS_ST2:  begin mul_a = st_r;  mul_b = st_r;  end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // half radius angle comes from bits above 16, other angles from the top word
  assign crd_angle = (cmd.crd_dst == vtst_pkg::CD_ST) ? prod_r[47:16] : prod_r[63:32];

  vtst_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.crd_start),
    .angle (crd_angle),
    .done  (crd_done),
    .cos_o (crd_cos),
    .sin_o (crd_sin)
  );

  // product, cordic results and haversine terms
  always_ff @(posedge clk) begin
    if (cmd.mul_sel != vtst_pkg::MS_NONE) prod_r <= mul_a * mul_b;
    if (cmd.crd_cap) begin
      case (cmd.crd_dst)
        vtst_pkg::CD_SDL: sdl_r <= crd_sin;
        vtst_pkg::CD_SDG: sdg_r <= crd_sin;
        vtst_pkg::CD_C1:  c1_r  <= crd_cos;
        vtst_pkg::CD_C2:  c2_r  <= crd_cos;
        vtst_pkg::CD_ST:  st_r  <= crd_sin;
        default: ;
      endcase
    end
    case (cmd.cap_sel)
      vtst_pkg::CP_P1:  p1_r  <= sh30;
      vtst_pkg::CP_P2:  p2_r  <= sh30;
      vtst_pkg::CP_HAV: hav_r <= 36'(p1_r) + 36'(sh30);
      default: ;
    endcase
  end

  // fence verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fence_r <= 1'b0;
    end else if (cmd.clear_fence) begin
      fence_r <= 1'b0;
    end else if (cmd.cap_sel == vtst_pkg::CP_CMP) begin
      fence_r <= hav_r > 36'(sh30);
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      lat_r <= in_latitude;
      lng_r <= in_longitude;
      spd_r <= in_speed;
      ign_r <= in_ignition_on;
      now_r <= in_now_ms;
    end
  end

  // next guard state from the captured word
  always_comb begin
    mode_nxt   = mode_r;
    stolen_nxt = stolen_r;
    locked_nxt = locked_r;
    ss_nxt     = ss_r;
    slat_nxt   = slat_r;
    slng_nxt   = slng_r;
    sspd_nxt   = sspd_r;
    ofence_nxt = 1'b0;
    clr_cfg    = 1'b0;
    case (op_r)
      vtst_pkg::OP_UPDATE: begin
        if (mode_r != vtst_pkg::MD_LOCKDOWN && mode_r != vtst_pkg::MD_RECOVERED) begin
          slat_nxt = lat_r;
          slng_nxt = lng_r;
          sspd_nxt = spd_r;
          if (!ign_r && spd_r >= thr_r) begin
            if (mode_nxt == vtst_pkg::MD_NORMAL) begin
              mode_nxt = vtst_pkg::MD_SUSPICIOUS;
              ss_nxt   = now_r;
            end
          end else if (ign_r && mode_nxt == vtst_pkg::MD_SUSPICIOUS) begin
            mode_nxt = vtst_pkg::MD_NORMAL;
            ss_nxt   = '0;
          end
          if (fence_r) begin
            ofence_nxt = 1'b1;
            if (mode_nxt != vtst_pkg::MD_STOLEN) begin
              mode_nxt   = vtst_pkg::MD_STOLEN;
              stolen_nxt = 1'b1;
            end
          end
          if (mode_nxt == vtst_pkg::MD_SUSPICIOUS && (now_r - ss_nxt) >= timeout_r) begin
            mode_nxt   = vtst_pkg::MD_STOLEN;
            stolen_nxt = 1'b1;
          end
        end
      end
      vtst_pkg::OP_LOCK_ON: begin
        mode_nxt   = vtst_pkg::MD_LOCKDOWN;
        locked_nxt = 1'b1;
        stolen_nxt = 1'b1;
      end
      vtst_pkg::OP_LOCK_OFF: begin
        mode_nxt   = vtst_pkg::MD_RECOVERED;
        locked_nxt = 1'b0;
        stolen_nxt = 1'b0;
      end
      vtst_pkg::OP_THEFT: begin
        stolen_nxt = 1'b1;
        if (mode_r == vtst_pkg::MD_NORMAL || mode_r == vtst_pkg::MD_SUSPICIOUS)
          mode_nxt = vtst_pkg::MD_STOLEN;
      end
      vtst_pkg::OP_CLEAR: begin
        mode_nxt   = vtst_pkg::MD_NORMAL;
        stolen_nxt = 1'b0;
        locked_nxt = 1'b0;
        ss_nxt     = '0;
        slat_nxt   = '0;
        slng_nxt   = '0;
        sspd_nxt   = '0;
        clr_cfg    = 1'b1;
      end
      default: ;
    endcase
  end

  // guard state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= vtst_pkg::MD_NORMAL;
      stolen_r  <= 1'b0;
      locked_r  <= 1'b0;
      ss_r      <= '0;
      slat_r    <= '0;
      slng_r    <= '0;
      sspd_r    <= '0;
      geo_on_r  <= 1'b0;
      clat_r    <= '0;
      clng_r    <= '0;
      radius_r  <= vtst_pkg::RADIUS_RST;
      thr_r     <= vtst_pkg::THR_RST;
      timeout_r <= vtst_pkg::TIMEOUT_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          vtst_pkg::REG_GEOFENCE_ON:  geo_on_r  <= cfg_wdata[0];
          vtst_pkg::REG_CENTER_LAT:   clat_r    <= cfg_wdata[30:0];
          vtst_pkg::REG_CENTER_LNG:   clng_r    <= cfg_wdata;
          vtst_pkg::REG_RADIUS:       radius_r  <= cfg_wdata[24:0];
          vtst_pkg::REG_MOTION_THR:   thr_r     <= cfg_wdata[15:0];
          vtst_pkg::REG_SUSP_TIMEOUT: timeout_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        mode_r   <= mode_nxt;
        stolen_r <= stolen_nxt;
        locked_r <= locked_nxt;
        ss_r     <= ss_nxt;
        slat_r   <= slat_nxt;
        slng_r   <= slng_nxt;
        sspd_r   <= sspd_nxt;
        if (clr_cfg) begin
          geo_on_r <= 1'b0;
          clat_r   <= '0;
          clng_r   <= '0;
          radius_r <= vtst_pkg::RADIUS_RST;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_guard_mode     <= mode_nxt;
      out_stolen_flag    <= stolen_nxt;
      out_lockdown_flag  <= locked_nxt;
      out_block_otp      <= locked_nxt || mode_nxt == vtst_pkg::MD_LOCKDOWN ||
                            mode_nxt == vtst_pkg::MD_STOLEN;
      out_outside_fence  <= ofence_nxt;
      out_last_latitude  <= slat_nxt;
      out_last_longitude <= slng_nxt;
      out_last_speed     <= sspd_nxt;
    end
  end

  // status to the controller
  assign sts.need_fence = op_r == vtst_pkg::OP_UPDATE && geo_on_r &&
                          mode_r != vtst_pkg::MD_LOCKDOWN &&
                          mode_r != vtst_pkg::MD_RECOVERED;
  assign sts.hr_big     = |prod_r[67:46];
  assign sts.crd_done   = crd_done;

endmodule

`default_nettype wire

// ----- rtl/vtst_ctrl.sv -----
// controller: handshakes and sequencing of the geofence computation
// depends on vtst_pkg
`default_nettype none

module vtst_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire vtst_pkg::sts_t      sts,
  output vtst_pkg::cmd_t           cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_MUL, ST_START, ST_WAIT, ST_PROD, ST_FINISH
  } state_t;

  localparam logic [2:0] PSTEP_LAST = 3'd5;

  state_t             state_r;
  vtst_pkg::crd_dst_t ang_r, ang_nxt;
  logic [2:0]         pstep_r;
  logic               out_valid_r;
  vtst_pkg::mul_sel_t ang_mul;

  // per-angle operand pair and the angle after it
  always_comb begin
    case (ang_r)
      vtst_pkg::CD_SDL: begin ang_mul = vtst_pkg::MS_DLAT; ang_nxt = vtst_pkg::CD_SDG; end
      vtst_pkg::CD_SDG: begin ang_mul = vtst_pkg::MS_DLNG; ang_nxt = vtst_pkg::CD_C1;  end
      vtst_pkg::CD_C1:  begin ang_mul = vtst_pkg::MS_CLAT; ang_nxt = vtst_pkg::CD_C2;  end
      vtst_pkg::CD_C2:  begin ang_mul = vtst_pkg::MS_LAT;  ang_nxt = vtst_pkg::CD_ST;  end
      vtst_pkg::CD_ST:  begin ang_mul = vtst_pkg::MS_RAD;  ang_nxt = vtst_pkg::CD_SDL; end
      default:          begin ang_mul = vtst_pkg::MS_NONE; ang_nxt = vtst_pkg::CD_SDL; end
    endcase
  end

  // command decode
  always_comb begin
    cmd         = '0;
    cmd.crd_dst = ang_r;
    case (state_r)
      ST_IDLE:  cmd.load = in_valid;
      ST_CHECK: cmd.clear_fence = 1'b1;
      ST_MUL:   cmd.mul_sel = ang_mul;
      ST_START: cmd.crd_start = !(ang_r == vtst_pkg::CD_ST && sts.hr_big);
      ST_WAIT:  cmd.crd_cap = sts.crd_done;
      ST_PROD: begin
        case (pstep_r)
          3'd0: cmd.mul_sel = vtst_pkg::MS_SDL2;
          3'd1: begin cmd.cap_sel = vtst_pkg::CP_P1;  cmd.mul_sel = vtst_pkg::MS_C1C2; end
          3'd2: begin cmd.cap_sel = vtst_pkg::CP_P2;  cmd.mul_sel = vtst_pkg::MS_SDG2; end
          3'd3: cmd.mul_sel = vtst_pkg::MS_P2P3;
          3'd4: begin cmd.cap_sel = vtst_pkg::CP_HAV; cmd.mul_sel = vtst_pkg::MS_ST2;  end
          default: cmd.cap_sel = vtst_pkg::CP_CMP;
        endcase
      end
      ST_FINISH: cmd.commit = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ang_r       <= vtst_pkg::CD_SDL;
      pstep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result word: set on commit, cleared once taken
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_valid) state_r <= ST_CHECK;
        ST_CHECK: begin
          ang_r   <= vtst_pkg::CD_SDL;
          state_r <= sts.need_fence ? ST_MUL : ST_FINISH;
        end
        ST_MUL: state_r <= ST_START;
        ST_START: begin
          if (ang_r == vtst_pkg::CD_ST && sts.hr_big) state_r <= ST_FINISH;
          else state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (sts.crd_done) begin
            if (ang_r == vtst_pkg::CD_ST) begin
              pstep_r <= '0;
              state_r <= ST_PROD;
            end else begin
              ang_r   <= ang_nxt;
              state_r <= ST_MUL;
            end
          end
        end
        ST_PROD: begin
          if (pstep_r == PSTEP_LAST) state_r <= ST_FINISH;
          else pstep_r <= pstep_r + 3'd1;
        end
        ST_FINISH: begin
          if (cmd.commit) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;

  // one word in flight at a time
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // every commit presents a result
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without result");

  // the cordic is only started when it is waited on next
  a_cordic_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.crd_start |=> state_r == ST_WAIT)
    else $error("cordic started outside the angle sequence");

endmodule

`default_nettype wire

// ----- rtl/vehicle_theft_state_tracker.sv -----
// top level of the vehicle theft state tracker: controller plus datapath
// depends on vtst_pkg, vtst_ctrl, vtst_dp
`default_nettype none

// Takes one word at a time: position updates and security events, and returns
// one status word per input word. Lockdown, unlock, theft report, guard reset
// and updates with the geofence off go from the check state straight to the
// finish state. An update checked against an enabled geofence runs five
// sine/cosine evaluations on one shared iterative cordic (one micro-rotation
// per cycle) plus six steps on one shared 34x34 multiplier. Angles that
// reach a quarter turn or more for the radius skip the last cordic run and
// the product steps. A finished word waits in the output register while the
// next input word is taken in.
module vehicle_theft_state_tracker #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          in_operation,
  input  wire logic signed [30:0]  in_latitude,
  input  wire logic signed [31:0]  in_longitude,
  input  wire logic [15:0]         in_speed,
  input  wire logic                in_ignition_on,
  input  wire logic [31:0]         in_now_ms,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_guard_mode,
  output logic                     out_stolen_flag,
  output logic                     out_lockdown_flag,
  output logic                     out_block_otp,
  output logic                     out_outside_fence,
  output logic signed [30:0]       out_last_latitude,
  output logic signed [31:0]       out_last_longitude,
  output logic [15:0]              out_last_speed
);

  vtst_pkg::cmd_t cmd;
  vtst_pkg::sts_t sts;

  vtst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vtst_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_operation       (in_operation),
    .in_latitude        (in_latitude),
    .in_longitude       (in_longitude),
    .in_speed           (in_speed),
    .in_ignition_on     (in_ignition_on),
    .in_now_ms          (in_now_ms),
    .out_guard_mode     (out_guard_mode),
    .out_stolen_flag    (out_stolen_flag),
    .out_lockdown_flag  (out_lockdown_flag),
    .out_block_otp      (out_block_otp),
    .out_outside_fence  (out_outside_fence),
    .out_last_latitude  (out_last_latitude),
    .out_last_longitude (out_last_longitude),
    .out_last_speed     (out_last_speed)
  );

endmodule

`default_nettype wire
